FILE: design/hmrl_pkg.sv
// ============================================================================
// hmrl_pkg
// Shared types, constants and the FNV-1a hash step for the message rate limiter.
// ============================================================================
package hmrl_pkg;

    // Bucket table geometry (power of two, 16 to 4096)
    localparam int BUCKETS = 256;
    localparam int IDX_W   = $clog2(BUCKETS);

    // FNV-1a 64-bit constants
    localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
    localparam logic [63:0] FNV_PRIME = 64'h0000_0100_0000_01B3;

    // Register file
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PER_SECOND  = 1'd1;
    localparam logic [31:0] MAX_PER_SECOND_RESET = 32'd100;
    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    // Item function codes
    typedef enum logic [1:0] {
        FUNC_MODULE  = 2'd0,
        FUNC_LINE    = 2'd1,
        FUNC_MESSAGE = 2'd2,
        FUNC_DECIDE  = 2'd3
    } func_t;

    // Input transaction
    typedef struct packed {
        func_t       func;
        logic [7:0]  data_byte;
        logic [30:0] line_number;
        logic [31:0] now_sec;
    } hmrl_in_t;

    // Result transaction
    typedef struct packed {
        logic        suppress;
        logic        first_suppressed;
        logic        flush_valid;
        logic [31:0] flushed_count;
    } hmrl_out_t;

    // One bucket entry
    typedef struct packed {
        logic [63:0] key;
        logic [31:0] second;
        logic [31:0] count;
    } bucket_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic mix;     // fold one hash item
        logic decide;  // latch key, start bucket read
        logic eval;    // bucket data ready: decide and write back
    } hmrl_ctl_t;

    // One FNV-1a step: xor, then multiply by the prime as shifts and adds
    // (prime = 2^40 + 2^8 + 179, 179 = 128 + 32 + 16 + 2 + 1)
    function automatic logic [63:0] fnv_mix(input logic [63:0] h, input logic [63:0] v);
        logic [63:0] x;
        begin
            x = h ^ v;
            fnv_mix = (x << 40) + (x << 8) + (x << 7) + (x << 5)
                    + (x << 4) + (x << 1) + x;
        end
    endfunction

endpackage

FILE: design/hmrl_ram.sv
// ============================================================================
// hmrl_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module hmrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/hmrl_ctrl.sv
// ============================================================================
// hmrl_ctrl
// Controller: accepts transactions and sequences the bucket read-modify-write.
// ============================================================================
module hmrl_ctrl
    import hmrl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  func_t     func,
    output logic      busy,
    output logic      done,
    output hmrl_ctl_t ctl
);

    typedef enum logic {
        ST_IDLE,
        ST_EVAL
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   accept;

    assign busy   = (state_reg == ST_EVAL);
    assign accept = start && !busy;

    // Decode the accepted transaction into datapath commands
    always_comb
    begin
        ctl.mix    = accept && (func != FUNC_DECIDE);
        ctl.decide = accept && (func == FUNC_DECIDE);
        ctl.eval   = (state_reg == ST_EVAL);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (ctl.decide)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and the result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_EVAL);
        end
    end

    assign done = done_reg;

`ifndef ASSERT_OFF
    // Evaluation lasts exactly one cycle
    a_eval_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("evaluation held longer than one cycle");

    // Every evaluation produces a result strobe
    a_eval_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done)
        else $error("evaluation without result strobe");

    // A result strobe only follows an evaluation
    a_done_after_eval: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without evaluation");
`endif

endmodule

FILE: design/hmrl_datapath.sv
// ============================================================================
// hmrl_datapath
// Datapath: running FNV-1a hash, bucket table and the rate decision.
// ============================================================================
module hmrl_datapath
    import hmrl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  hmrl_ctl_t             ctl,
    input  hmrl_in_t              cmd,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output hmrl_out_t             result
);

    // Configuration
    logic        throttle_enable_reg;
    logic [31:0] max_per_second_reg;

    // Hash and latched decide transaction
    logic [63:0]      hash_reg;
    logic [63:0]      hash_next;
    logic [63:0]      key_reg;
    logic [31:0]      now_reg;
    logic [IDX_W-1:0] idx_reg;

    // Bucket table
    logic [BUCKETS-1:0] valid_reg;
    logic               hit_valid_reg;
    bucket_t            ram_rdata;
    bucket_t            entry;
    bucket_t            wr_entry;
    logic               wr_en;

    // Decision terms
    logic        new_second;
    logic        stuck;
    logic        same_key;
    logic        over;
    logic [31:0] cnt_inc;
    hmrl_out_t   res_next;
    hmrl_out_t   result_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            throttle_enable_reg <= 1'b0;
            max_per_second_reg  <= MAX_PER_SECOND_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_THROTTLE_ENABLE: throttle_enable_reg <= cfg_data[0];
                REG_MAX_PER_SECOND:  max_per_second_reg  <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // Fold a hash item, restore the basis on decide
    always_comb
    begin
        hash_next = hash_reg;
        if (ctl.mix)
        begin
            if (cmd.func == FUNC_LINE)
            begin
                hash_next = fnv_mix(hash_reg, {33'd0, cmd.line_number});
            end
            else
            begin
                hash_next = fnv_mix(hash_reg, {56'd0, cmd.data_byte});
            end
        end
        else if (ctl.decide)
        begin
            hash_next = FNV_BASIS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= FNV_BASIS;
        end
        else
        begin
            hash_reg <= hash_next;
        end
    end

    // Latch key, second and bucket index of the decide transaction
    always_ff @(posedge clk)
    begin
        if (ctl.decide)
        begin
            key_reg       <= hash_reg;
            now_reg       <= cmd.now_sec;
            idx_reg       <= hash_reg[IDX_W-1:0];
            hit_valid_reg <= valid_reg[hash_reg[IDX_W-1:0]];
        end
    end

    hmrl_ram #(
        .WIDTH ($bits(bucket_t)),
        .DEPTH (BUCKETS)
    ) u_bucket_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (idx_reg),
        .wdata (wr_entry),
        .re    (ctl.decide),
        .raddr (hash_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // Never-written buckets read as all zero
    assign entry = hit_valid_reg ? ram_rdata : '0;

    // Rate decision and bucket update
    always_comb
    begin
        new_second = (entry.second != now_reg);
        stuck      = (entry.second != 32'd0) && (entry.count > max_per_second_reg);
        same_key   = (entry.key == key_reg);
        over       = (entry.count >= max_per_second_reg);
        cnt_inc    = (entry.count == COUNT_MAX) ? entry.count : entry.count + 32'd1;

        res_next = '0;
        wr_en    = 1'b0;
        wr_entry = entry;

        if (ctl.eval && throttle_enable_reg)
        begin
            if (new_second)
            begin
                // Stuck bucket: pass and leave it alone
                if (!stuck)
                begin
                    wr_en    = 1'b1;
                    wr_entry = '{key: key_reg, second: now_reg, count: 32'd1};
                end
            end
            else if (same_key)
            begin
                wr_en          = 1'b1;
                wr_entry.count = cnt_inc;
                if (over)
                begin
                    res_next.suppress         = 1'b1;
                    res_next.first_suppressed =
                        ((cnt_inc - max_per_second_reg) == 32'd1);
                end
            end
            else
            begin
                // Take over the bucket, report what the old key dropped
                if (entry.count > max_per_second_reg)
                begin
                    res_next.flush_valid   = 1'b1;
                    res_next.flushed_count = entry.count - max_per_second_reg;
                end
                wr_en          = 1'b1;
                wr_entry.key   = key_reg;
                wr_entry.count = 32'd1;
            end
        end
    end

    // Mark written buckets valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[idx_reg] <= 1'b1;
        end
    end

    // Register the result transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_reg <= '0;
        end
        else if (ctl.eval)
        begin
            result_reg <= res_next;
        end
    end

    assign result = result_reg;

`ifndef ASSERT_OFF
    // First suppression is always a suppression
    a_first_implies_sup: assert property (@(posedge clk) disable iff (!rst_n)
        result_reg.first_suppressed |-> result_reg.suppress)
        else $error("first_suppressed without suppress");

    // A flush never comes with a suppression, and always carries a nonzero count
    a_flush_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        result_reg.flush_valid |-> !result_reg.suppress &&
                                   (result_reg.flushed_count != 32'd0))
        else $error("flush result inconsistent");

    // The hash restarts from the basis after every decide
    a_hash_restored: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.decide |=> (hash_reg == FNV_BASIS))
        else $error("running hash not restored after decide");
`endif

endmodule

FILE: design/hashed_message_rate_limiter_top.sv
// ============================================================================
// hashed_message_rate_limiter_top
// Per-key message rate limiter keyed by a running FNV-1a 64-bit hash.
// ============================================================================
//
//  Channel  | Ports                              | Transfer
//  ---------+------------------------------------+--------------------------
//  input    | start, busy, cmd                   | start high while busy low
//  result   | done, result                       | done high for one cycle
//  config   | cfg_we, cfg_index, cfg_data        | cfg_we high
//
//  Hash items (module byte, line number, message byte) are folded into the hash as accepted.
//  A decide starts the bucket RAM's registered read; busy is then high for
//  the read-modify-write of the bucket.
//  The result strobe rises in the same cycle in which busy falls.
//  Reset is asynchronous; buckets read as empty through per-entry valid bits.
//  The receiver cannot stall: each result is shown for exactly one cycle.
//
module hashed_message_rate_limiter_top
    import hmrl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  hmrl_in_t              cmd,
    output logic                  done,
    output hmrl_out_t             result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    hmrl_ctl_t ctl;

    hmrl_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (cmd.func),
        .busy  (busy),
        .done  (done),
        .ctl   (ctl)
    );

    hmrl_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result)
    );

endmodule

FILE: dv/hashed_message_rate_limiter_checker.sv
// ============================================================================
// hashed_message_rate_limiter_checker
// Watches the input, result and register channels of the rate limiter,
// predicts every decision from its own hash and bucket table, and compares
// each result transaction field by field with the oldest pending prediction.
// ============================================================================
module hashed_message_rate_limiter_checker
    import hmrl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  hmrl_in_t              cmd,
    input  logic                  done,
    input  hmrl_out_t             result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    outstanding,
    output int                    decisions_checked,
    output int                    suppressed_seen,
    output int                    first_seen,
    output int                    flushes_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    // Shadow of the key hash, the bucket table and the registers
    logic [63:0] key_hash;
    logic [63:0] slot_key    [BUCKETS];
    logic [31:0] slot_second [BUCKETS];
    logic [31:0] slot_count  [BUCKETS];
    logic        throttle_on;
    logic [31:0] rate_limit;

    // Decisions predicted but not yet seen on the result port
    hmrl_out_t   expected_decisions[$];

    // Apply the bucket rule for one decide and return the expected verdict
    function automatic hmrl_out_t predict_decision(input logic [63:0] key,
                                                   input logic [31:0] now);
        hmrl_out_t        verdict;
        logic [IDX_W-1:0] idx;
        logic [31:0]      cnt;
        logic [31:0]      excess;
        logic             over;
        verdict = '0;
        if (!throttle_on)
            return verdict;
        idx = key[IDX_W-1:0];
        cnt = slot_count[idx];
        if (slot_second[idx] != now)
        begin
            // New second: an over-limit bucket stays stuck, otherwise restart it
            if (!(slot_second[idx] != 32'd0 && cnt > rate_limit))
            begin
                slot_second[idx] = now;
                slot_key[idx]    = key;
                slot_count[idx]  = 32'd1;
            end
        end
        else if (slot_key[idx] == key)
        begin
            // Same key in the same second: count up, saturating
            over = (cnt >= rate_limit);
            if (cnt != COUNT_MAX)
                cnt = cnt + 32'd1;
            slot_count[idx] = cnt;
            if (over)
            begin
                excess                   = cnt - rate_limit;
                verdict.suppress         = 1'b1;
                verdict.first_suppressed = (excess == 32'd1);
            end
        end
        else
        begin
            // Another key takes the bucket; report what the old key had dropped
            if (cnt > rate_limit)
            begin
                verdict.flush_valid   = 1'b1;
                verdict.flushed_count = cnt - rate_limit;
            end
            slot_key[idx]   = key;
            slot_count[idx] = 32'd1;
        end
        return verdict;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        hmrl_out_t want;
        logic      bad;
        int        i;
        if (!rst_n)
        begin
            key_hash    = FNV_BASIS;
            throttle_on = 1'b0;
            rate_limit  = MAX_PER_SECOND_RESET;
            for (i = 0; i < BUCKETS; i++)
            begin
                slot_key[i]    = '0;
                slot_second[i] = '0;
                slot_count[i]  = '0;
            end
            expected_decisions.delete();
            mismatches        = 0;
            outstanding       = 0;
            decisions_checked = 0;
            suppressed_seen   = 0;
            first_seen        = 0;
            flushes_seen      = 0;
        end
        else
        begin
            // Check a result transaction against the oldest prediction
            if (done)
            begin
                if (expected_decisions.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                    begin
                        $write("%0t: result with no decision pending: ", $time);
                        $display("suppress=%0b first=%0b flush=%0b count=%0d",
                                 result.suppress, result.first_suppressed,
                                 result.flush_valid, result.flushed_count);
                    end
                end
                else
                begin
                    want = expected_decisions.pop_front();
                    decisions_checked++;
                    suppressed_seen += want.suppress;
                    first_seen      += want.first_suppressed;
                    flushes_seen    += want.flush_valid;
                    bad = (result.suppress !== want.suppress)
                       || (result.first_suppressed !== want.first_suppressed)
                       || (result.flush_valid !== want.flush_valid)
                       || (result.flushed_count !== want.flushed_count);
                    if (bad)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                        begin
                            $write("%0t: decision mismatch: expected ", $time);
                            $write("suppress=%0b first=%0b flush=%0b count=%0d, ",
                                   want.suppress, want.first_suppressed,
                                   want.flush_valid, want.flushed_count);
                            $display("actual suppress=%0b first=%0b flush=%0b count=%0d",
                                     result.suppress, result.first_suppressed,
                                     result.flush_valid, result.flushed_count);
                        end
                    end
                end
            end

            // Track register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_THROTTLE_ENABLE: throttle_on = cfg_data[0];
                    REG_MAX_PER_SECOND:  rate_limit  = cfg_data;
                    default: ;
                endcase
            end

            // Fold hash items, predict decides
            if (start && !busy)
            begin
                case (cmd.func) inside
                    FUNC_MODULE, FUNC_MESSAGE:
                        key_hash = (key_hash ^ {56'd0, cmd.data_byte}) * FNV_PRIME;
                    FUNC_LINE:
                        key_hash = (key_hash ^ {33'd0, cmd.line_number}) * FNV_PRIME;
                    default:
                    begin
                        expected_decisions.push_back(
                            predict_decision(key_hash, cmd.now_sec));
                        key_hash = FNV_BASIS;
                    end
                endcase
            end
            outstanding = expected_decisions.size();
        end
    end

endmodule

FILE: dv/hashed_message_rate_limiter_top_tb.sv
// ============================================================================
// hashed_message_rate_limiter_top_tb
// Drives message keys and decide transactions into the rate limiter under
// several register settings: a short directed pass over the field extremes,
// suppression, flushes, stuck buckets and the unused-second case, then random
// message streams with repeated and colliding keys, noise and random gaps.
// ============================================================================
module hashed_message_rate_limiter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import hmrl_pkg::*;

    localparam int ITEM_TARGET   = 1150;
    localparam int PHASE_ITEMS   = 120;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int POOL          = 6;
    localparam int KEY_BYTES     = 8;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    hmrl_in_t              cmd;
    logic                  done;
    hmrl_out_t             result;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int mismatches;
    int outstanding;
    int decisions_checked;
    int suppressed_seen;
    int first_seen;
    int flushes_seen;

    logic        in_taken;
    int          items_sent;
    int          phase_count;
    int          idle_cycles;
    int          gap_mode;
    int          sel;
    logic [31:0] cur_sec;

    // Message key pool: module bytes first, then message bytes
    logic [7:0]  key_bytes   [POOL][KEY_BYTES];
    int          key_mod_len [POOL];
    int          key_msg_len [POOL];
    logic [30:0] key_line    [POOL];

    hashed_message_rate_limiter_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    hashed_message_rate_limiter_checker checker_i (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .cmd               (cmd),
        .done              (done),
        .result            (result),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .mismatches        (mismatches),
        .outstanding       (outstanding),
        .decisions_checked (decisions_checked),
        .suppressed_seen   (suppressed_seen),
        .first_seen        (first_seen),
        .flushes_seen      (flushes_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Record whether the last rising edge took an input transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_taken <= 1'b0;
        else
            in_taken <= start && !busy;
    end

    // Abort when no channel moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || cfg_we)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("** hashed_message_rate_limiter_top: FAILED **");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Fully random transaction; callers override the fields that matter
    function automatic hmrl_in_t noise_item();
        hmrl_in_t it;
        it.func        = func_t'($urandom_range(0, 3));
        it.data_byte   = 8'($urandom);
        it.line_number = 31'($urandom);
        it.now_sec     = $urandom;
        return it;
    endfunction

    // Back to back in gap mode 0; otherwise mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (gap_mode == 0)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Present one input transaction and hold it until the block takes it
    task automatic send_item(input hmrl_in_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        cmd   <= it;
        @(negedge clk);
        while (!in_taken)
            @(negedge clk);
        items_sent++;
    endtask

    task automatic send_decide(input logic [31:0] sec);
        hmrl_in_t it;
        it         = noise_item();
        it.func    = FUNC_DECIDE;
        it.now_sec = sec;
        send_item(it);
    endtask

    // Send a whole key, then decide. Variants flip line bits 8 and 30 of the
    // line number, so they hash as a different key.
    task automatic send_message(input int k, input logic [1:0] v, input logic [31:0] sec);
        hmrl_in_t it;
        int       j;
        for (j = 0; j < key_mod_len[k]; j++)
        begin
            it           = noise_item();
            it.func      = FUNC_MODULE;
            it.data_byte = key_bytes[k][j];
            send_item(it);
        end
        it             = noise_item();
        it.func        = FUNC_LINE;
        it.line_number = key_line[k] ^ {v[1], 21'd0, v[0], 8'd0};
        send_item(it);
        for (j = 0; j < key_msg_len[k]; j++)
        begin
            it           = noise_item();
            it.func      = FUNC_MESSAGE;
            it.data_byte = key_bytes[k][key_mod_len[k] + j];
            send_item(it);
        end
        send_decide(sec);
    endtask

    // Drain pending decisions, let the block settle, then write both registers
    task automatic set_config(input logic en, input logic [31:0] limit);
        logic [31:0] word;
        word    = $urandom;
        word[0] = en;
        start <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_THROTTLE_ENABLE;
        cfg_data  <= word;
        @(negedge clk);
        cfg_index <= REG_MAX_PER_SECOND;
        cfg_data  <= limit;
        @(negedge clk);
        cfg_we <= 1'b0;
        phase_count++;
    endtask

    // Random keys: at most seven bytes shared between module and message
    function automatic void refill_keys();
        int k;
        int j;
        for (k = 0; k < POOL; k++)
        begin
            key_mod_len[k] = $urandom_range(0, 3);
            key_msg_len[k] = $urandom_range(0, 4);
            key_line[k]    = 31'($urandom);
            for (j = 0; j < KEY_BYTES; j++)
                key_bytes[k][j] = 8'($urandom);
        end
    endfunction

    // Mostly well-formed messages from a few hot keys, with time advancing
    task automatic random_phase(input logic en, input logic [31:0] limit, input int n_items);
        int         stop_at;
        int         active;
        int         r;
        logic [1:0] v;
        set_config(en, limit);
        refill_keys();
        gap_mode = $urandom_range(0, 2);
        active   = $urandom_range(2, POOL);
        cur_sec  = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 50);
        stop_at  = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            r = $urandom_range(0, 99);
            if (r < 5)
                cur_sec = cur_sec + 32'd1;
            else if (r == 5)
                cur_sec = $urandom;
            else if (r == 6)
                cur_sec = 32'd0;
            else if (r == 7)
                cur_sec = 32'hFFFF_FFFF;
            v = ($urandom_range(0, 99) < 60) ? 2'd0 : 2'($urandom_range(1, 3));
            r = $urandom_range(0, 99);
            if (r < 80)
                send_message($urandom_range(0, active - 1), v, cur_sec);
            else if (r < 85)
                send_message($urandom_range(0, active - 1), v, cur_sec - 32'd1);
            else if (r < 92)
                send_decide(cur_sec);
            else
                repeat ($urandom_range(1, 3)) send_item(noise_item());
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = '0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        items_sent  = 0;
        phase_count = 0;
        gap_mode    = 1;
        cur_sec     = '0;
        refill_keys();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed keys: byte, line and second extremes; a line-only key
        key_mod_len[0]  = 2;
        key_msg_len[0]  = 1;
        key_bytes[0][0] = 8'h00;
        key_bytes[0][1] = 8'hFF;
        key_bytes[0][2] = 8'hA5;
        key_line[0]     = 31'h7FFF_FFFF;
        key_mod_len[1]  = 0;
        key_msg_len[1]  = 0;
        key_line[1]     = 31'd0;

        // Throttling off after reset: every decide passes untouched
        send_message(0, 2'd0, 32'hFFFF_FFFF);
        send_decide(32'd0);

        // Limit of one: suppress, first flag, flush, stuck bucket, unused second
        set_config(1'b1, 32'd1);
        repeat (3) send_message(1, 2'd0, 32'd1);
        repeat (3) send_message(1, 2'd1, 32'd1);
        send_message(1, 2'd1, 32'd2);
        repeat (2) send_decide(32'd0);
        send_decide(32'hFFFF_FFFF);

        // Zero limit: every repeat within a second is dropped
        random_phase(1'b1, 32'd0, PHASE_ITEMS);

        // Burst of one key past the reset limit, then a new second
        set_config(1'b1, MAX_PER_SECOND_RESET);
        gap_mode = $urandom_range(0, 1);
        cur_sec  = $urandom_range(1, 1000);
        repeat (MAX_PER_SECOND_RESET + 5) send_decide(cur_sec);
        send_decide(cur_sec + 32'd1);

        // Cycle through settings until the item budget is spent
        sel = 0;
        while (items_sent < ITEM_TARGET)
        begin
            case (sel % 6)
                0:       random_phase(1'b1, 32'd1, PHASE_ITEMS);
                1:       random_phase(1'b1, 32'd2, PHASE_ITEMS);
                2:       random_phase(1'b0, $urandom, PHASE_ITEMS);
                3:       random_phase(1'b1, $urandom_range(1, 4), PHASE_ITEMS);
                4:       random_phase(1'b1, 32'hFFFF_FFFF, PHASE_ITEMS);
                default: random_phase(1'b1, 32'd3, PHASE_ITEMS);
            endcase
            sel++;
        end

        // Drain and give the block time to show any stray result
        start <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Sent %0d input transactions over %0d register settings.",
                 items_sent, phase_count);
        $display("Checked %0d decisions: %0d suppressions (%0d first), %0d flushes, %0d mismatches.",
                 decisions_checked, suppressed_seen, first_seen, flushes_seen, mismatches);
        if (mismatches == 0)
            $display("** hashed_message_rate_limiter_top: PASSED **");
        else
            $display("** hashed_message_rate_limiter_top: FAILED **");
        $finish;
    end

endmodule

FILE: hashed_message_rate_limiter_top.f
design/hmrl_pkg.sv
design/hmrl_ram.sv
design/hmrl_ctrl.sv
design/hmrl_datapath.sv
design/hashed_message_rate_limiter_top.sv
dv/hashed_message_rate_limiter_checker.sv
dv/hashed_message_rate_limiter_top_tb.sv
